FILE: rtl/core/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the speed frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdW       = 4;
  localparam int unsigned NumVals   = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned ByteIdxW  = 3;

  // Bytes per record: one id byte and six data bytes.
  localparam logic [ByteIdxW-1:0] REC_LAST_BYTE = 3'd6;
  localparam logic [ByteIdxW-1:0] REC_ID_BYTE   = 3'd0;

  localparam logic [IdW-1:0] ID_MASK = 4'hF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TAIL_FIRST    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TAIL_SECOND   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OWN_ID        = 3'd4;

  // Held value slots, in output order.
  localparam logic [SlotW-1:0] SLOT_DIR_X   = 3'd0;
  localparam logic [SlotW-1:0] SLOT_SPEED_X = 3'd1;
  localparam logic [SlotW-1:0] SLOT_DIR_Y   = 3'd2;
  localparam logic [SlotW-1:0] SLOT_SPEED_Y = 3'd3;
  localparam logic [SlotW-1:0] SLOT_DIR_Z   = 3'd4;
  localparam logic [SlotW-1:0] SLOT_SPEED_Z = 3'd5;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [NumVals-1:0] vals_t;

  typedef struct packed {
    byte_t          header_first;
    byte_t          header_second;
    byte_t          tail_first;
    byte_t          tail_second;
    logic [IdW-1:0] own_id;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    logic  cleared;
    vals_t vals;
  } result_t;

  // Record data byte position to held value slot.
  function automatic logic [SlotW-1:0] slot_of_byte(input logic [ByteIdxW-1:0] k);
    logic [SlotW-1:0] s;
    case (k)
      3'd1:    s = SLOT_DIR_Y;
      3'd2:    s = SLOT_SPEED_Y;
      3'd3:    s = SLOT_DIR_X;
      3'd4:    s = SLOT_SPEED_X;
      3'd5:    s = SLOT_DIR_Z;
      3'd6:    s = SLOT_SPEED_Z;
      default: s = SLOT_DIR_X;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/speed_frame_parser_top.sv
// ----------------------------------------------------------------------------
// speed_frame_parser_top
// Byte-serial speed frame parser with a registered result port.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                payload
//   -------   ---------  -----------------------  -----------------------------
//   input     in         in_valid_i / in_stall_o  rx_byte_i
//   result    out        out_valid_o/out_stall_i  dir/speed x,y,z, cleared_o
//   config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Cycles: one byte per clock unless stalled; a result appears in the output
// register the cycle after the second tail byte is taken, set by the single
// state update. Reset: clears parse state, held values, config registers and
// the result register.
// Stalls: input is held off only while a result waits and the sink stalls.
// ----------------------------------------------------------------------------
module speed_frame_parser_top #(
  parameter int unsigned MAX_RECORDS = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     dir_x_o,
  output logic [7:0]                     speed_x_o,
  output logic [7:0]                     dir_y_o,
  output logic [7:0]                     speed_y_o,
  output logic [7:0]                     dir_z_o,
  output logic [7:0]                     speed_z_o,
  output logic                           cleared_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [sfp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i
);
  import sfp_pkg::*;

  cfg_t    cfg_q;
  result_t res;
  logic    accept;

  logic    out_valid_q, out_valid_d;
  logic    cleared_q;
  vals_t   vals_q;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata_i;
        CFG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata_i;
        CFG_TAIL_FIRST:    cfg_q.tail_first    <= cfg_wdata_i;
        CFG_TAIL_SECOND:   cfg_q.tail_second   <= cfg_wdata_i;
        CFG_OWN_ID:        cfg_q.own_id        <= cfg_wdata_i[IdW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold input only while the result register is full and stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  sfp_parser #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // Load a new result, drop a delivered one, otherwise hold.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vals_q    <= '0;
      cleared_q <= 1'b0;
    end else if (res.valid) begin
      vals_q    <= res.vals;
      cleared_q <= res.cleared;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dir_x_o     = vals_q[SLOT_DIR_X];
  assign speed_x_o   = vals_q[SLOT_SPEED_X];
  assign dir_y_o     = vals_q[SLOT_DIR_Y];
  assign speed_y_o   = vals_q[SLOT_SPEED_Y];
  assign dir_z_o     = vals_q[SLOT_DIR_Z];
  assign speed_z_o   = vals_q[SLOT_SPEED_Z];
  assign cleared_o   = cleared_q;

endmodule

FILE: rtl/core/sfp_parser.sv
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state machine and held value store; one byte per accepted transaction.
// ----------------------------------------------------------------------------
module sfp_parser #(
  parameter int unsigned MAX_RECORDS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sfp_pkg::byte_t    rx_byte_i,
  input  sfp_pkg::cfg_t     cfg_i,
  output sfp_pkg::result_t  res_o
);
  import sfp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);
  localparam logic [IdW-1:0] MaxRecId = IdW'(MAX_RECORDS);

  localparam logic [2:0] ST_HDR0  = 3'd0;
  localparam logic [2:0] ST_HDR1  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_REC   = 3'd3;
  localparam logic [2:0] ST_TAIL0 = 3'd4;
  localparam logic [2:0] ST_TAIL1 = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     rec_idx_q, rec_idx_d;
  logic [CntW-1:0]     rec_cnt_q, rec_cnt_d;
  logic [ByteIdxW-1:0] byte_idx_q, byte_idx_d;
  logic [IdW-1:0]      stored_id_q, stored_id_d;
  vals_t               held_q, held_d;

  logic [IdW-1:0]  nib;
  logic [CntW-1:0] clamped;
  logic            clear;

  assign nib     = rx_byte_i[IdW-1:0] & ID_MASK;
  assign clamped = (nib > MaxRecId) ? CntW'(MAX_RECORDS) : CntW'(nib);
  assign clear   = !((rx_byte_i == cfg_i.tail_second) && (rec_cnt_q != '0));

  always_comb begin
    state_d     = state_q;
    rec_idx_d   = rec_idx_q;
    rec_cnt_d   = rec_cnt_q;
    byte_idx_d  = byte_idx_q;
    stored_id_d = stored_id_q;
    held_d      = held_q;
    res_o       = '0;
    res_o.vals  = held_q;

    case (state_q)
      ST_HDR0: begin
        state_d = (rx_byte_i == cfg_i.header_first) ? ST_HDR1 : ST_HDR0;
      end
      ST_HDR1: begin
        state_d = (rx_byte_i == cfg_i.header_second) ? ST_COUNT : ST_HDR0;
      end
      ST_COUNT: begin
        rec_cnt_d  = clamped;
        rec_idx_d  = '0;
        byte_idx_d = REC_ID_BYTE;
        state_d    = (clamped == '0) ? ST_TAIL0 : ST_REC;
      end
      ST_REC: begin
        if (byte_idx_q == REC_ID_BYTE) begin
          // Keep the id only on a match, else zero.
          stored_id_d = (nib == cfg_i.own_id) ? nib : '0;
          byte_idx_d  = byte_idx_q + ByteIdxW'(1);
        end else begin
          if (stored_id_q == cfg_i.own_id) begin
            held_d[slot_of_byte(byte_idx_q)] = rx_byte_i;
          end
          if (byte_idx_q == REC_LAST_BYTE) begin
            byte_idx_d = REC_ID_BYTE;
            rec_idx_d  = rec_idx_q + CntW'(1);
            if (rec_idx_q + CntW'(1) >= rec_cnt_q) begin
              state_d = ST_TAIL0;
            end
          end else begin
            byte_idx_d = byte_idx_q + ByteIdxW'(1);
          end
        end
      end
      ST_TAIL0: begin
        state_d = (rx_byte_i == cfg_i.tail_first) ? ST_TAIL1 : ST_HDR0;
      end
      ST_TAIL1: begin
        res_o.valid   = 1'b1;
        res_o.cleared = clear;
        if (clear) begin
          held_d      = '0;
          rec_cnt_d   = '0;
          stored_id_d = '0;
          res_o.vals  = '0;
        end
        state_d = ST_HDR0;
      end
      default: begin
        state_d = ST_HDR0;
      end
    endcase

    if (!accept_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HDR0;
      rec_idx_q   <= '0;
      rec_cnt_q   <= '0;
      byte_idx_q  <= '0;
      stored_id_q <= '0;
      held_q      <= '0;
    end else if (accept_i) begin
      state_q     <= state_d;
      rec_idx_q   <= rec_idx_d;
      rec_cnt_q   <= rec_cnt_d;
      byte_idx_q  <= byte_idx_d;
      stored_id_q <= stored_id_d;
      held_q      <= held_d;
    end
  end

endmodule
